@@ design/range_min_segment_tree_unit_defines.svh @@
// Assertion macros shared by the range-minimum segment tree RTL.
// Plain text macros only; no other file is needed.
`ifndef RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/rmst_pkg.sv @@
// Package for the range-minimum segment tree: field widths, request codes,
// sentinel and the controller/datapath command and status structs. No dependencies.
package rmst_pkg;

  localparam int unsigned VAL_W      = 61;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned END_W      = 11;
  localparam int unsigned LEAVES_DEF = 1024;

  localparam logic [VAL_W-1:0] SENTINEL = VAL_W'(1) << 60;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch accepted request
    logic clr_step;  // write one sentinel entry of the clearing pass
    logic wr_leaf;   // write leaf, fetch its sibling
    logic rd_sib;    // fetch sibling of current node
    logic wr_up;     // write parent = min(node, sibling), climb
    logic q_lo;      // query: left boundary step
    logic q_hi;      // query: right boundary step, shift both bounds
    logic q_fin;     // query: load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic wr_oob;
    logic clr_last;
    logic at_root;
    logic lo_lt_hi;
  } dp_sts_t;

endpackage

@@ design/range_min_segment_tree_unit.sv @@
// Top level of the range-minimum segment tree unit.
// Uses rmst_pkg, rmst_ctrl and rmst_dp (which holds rmst_ram).
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_stall, in_req_type, in_position,    | in
//          | in_right_end, in_new_value                       |
//  out     | out_valid, out_stall, out_range_minimum          | out
//
// Sequencing: one request at a time. A write does one sibling read and one
//   parent write per level; a query does two boundary steps per level over
//   up to log2(LEAVES)+1 levels. Both are set by the single tree read port.
// Reset: synchronous, active low; afterwards a clearing pass writes the
//   sentinel 2^60 into all 2*LEAVES nodes, one per cycle, with in_stall high.
// Stalls: a finished query result sits in an output register; the next
//   request is accepted while it waits, and only a second finished query
//   waits for out_stall to drop.
// Writes at a position of LEAVES or more leave the tree unchanged.
module range_min_segment_tree_unit #(
  parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEF  // power of two, 2..65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [rmst_pkg::POS_W-1:0] in_position,
  input  logic [rmst_pkg::END_W-1:0] in_right_end,
  input  logic [rmst_pkg::VAL_W-1:0] in_new_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rmst_pkg::VAL_W-1:0] out_range_minimum
);

  import rmst_pkg::*;

  // command/status link between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clear pass, write climb, query walk, result handshake
  rmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: tree memory plus request, bound and accumulator registers
  rmst_dp #(.LEAVES(LEAVES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_right_end      (in_right_end),
    .in_new_value      (in_new_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_range_minimum (out_range_minimum)
  );

endmodule

@@ design/rmst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/rmst_dp.sv @@
// Datapath of the range-minimum segment tree: tree memory, node/bound
// registers, accumulators and result register. Uses rmst_pkg and rmst_ram.
`include "range_min_segment_tree_unit_defines.svh"
module rmst_dp #(
  parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_req_type,
  input  logic [rmst_pkg::POS_W-1:0] in_position,
  input  logic [rmst_pkg::END_W-1:0] in_right_end,
  input  logic [rmst_pkg::VAL_W-1:0] in_new_value,
  input  rmst_pkg::dp_cmd_t          cmd,
  output rmst_pkg::dp_sts_t          sts,
  output logic [rmst_pkg::VAL_W-1:0] out_range_minimum
);

  import rmst_pkg::*;

  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned AW = LW + 1;               // node address
  localparam int unsigned NW = LW + 2;               // bound, holds 2*LEAVES
  localparam int unsigned CW = (AW > END_W) ? AW : END_W;
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);

  logic [AW-1:0]    node_r, node_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic [NW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [VAL_W-1:0] lacc_r, lacc_nxt, racc_r, racc_nxt;
  logic             pend_l_r, pend_l_nxt, pend_r_r, pend_r_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [VAL_W-1:0] res_r, res_nxt;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  logic [CW-1:0]    pos_ext, end_ext, end_clamp;
  logic             empty;
  logic [AW-1:0]    sib, parent;
  logic [NW-1:0]    hm1;
  logic [VAL_W-1:0] up_min, lacc_upd, racc_upd, fin_min;

  rmst_ram #(.WIDTH(VAL_W), .DEPTH(2 * LEAVES)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_ext   = CW'(in_position);
  assign end_ext   = CW'(in_right_end);
  assign end_clamp = (end_ext > LEAVES_C) ? LEAVES_C : end_ext;
  assign empty     = pos_ext >= end_clamp;

  assign sib      = {node_r[AW-1:1], ~node_r[0]};
  assign parent   = {1'b0, node_r[AW-1:1]};
  assign hm1      = hi_r - NW'(1);
  assign up_min   = (rdata < cur_r) ? rdata : cur_r;
  assign lacc_upd = (rdata < lacc_r) ? rdata : lacc_r;
  assign racc_upd = (rdata < racc_r) ? rdata : racc_r;
  assign fin_min  = (racc_r < lacc_r) ? racc_r : lacc_r;

  assign sts.is_query = (in_req_type == REQ_QUERY);
  assign sts.wr_oob   = pos_ext >= LEAVES_C;
  assign sts.clr_last = &clr_r;
  assign sts.at_root  = (parent == AW'(1));
  assign sts.lo_lt_hi = lo_r < hi_r;

  always_comb begin
    we         = 1'b0;
    waddr      = node_r;
    wdata      = cur_r;
    re         = 1'b0;
    raddr      = sib;
    node_nxt   = node_r;
    cur_nxt    = cur_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    lacc_nxt   = lacc_r;
    racc_nxt   = racc_r;
    pend_l_nxt = pend_l_r;
    pend_r_nxt = pend_r_r;
    clr_nxt    = clr_r;
    res_nxt    = res_r;

    if (cmd.clr_step) begin
      we      = 1'b1;
      waddr   = clr_r;
      wdata   = SENTINEL;
      clr_nxt = clr_r + AW'(1);
    end

    if (cmd.load) begin
      node_nxt   = AW'(LEAVES) + AW'(pos_ext);
      cur_nxt    = in_new_value;
      lacc_nxt   = SENTINEL;
      racc_nxt   = SENTINEL;
      pend_l_nxt = 1'b0;
      pend_r_nxt = 1'b0;
      if (empty) begin
        lo_nxt = '0;
        hi_nxt = '0;
      end else begin
        lo_nxt = NW'(LEAVES) + NW'(pos_ext);
        hi_nxt = NW'(LEAVES) + NW'(end_clamp);
      end
    end

    if (cmd.wr_leaf) begin
      we = 1'b1;
      re = 1'b1;
    end

    if (cmd.rd_sib) begin
      re = 1'b1;
    end

    if (cmd.wr_up) begin
      we       = 1'b1;
      waddr    = parent;
      wdata    = up_min;
      cur_nxt  = up_min;
      node_nxt = parent;
    end

    if (cmd.q_lo) begin
      if (pend_r_r) begin
        racc_nxt = racc_upd;
      end
      pend_r_nxt = 1'b0;
      if (sts.lo_lt_hi && lo_r[0]) begin
        re         = 1'b1;
        raddr      = lo_r[AW-1:0];
        pend_l_nxt = 1'b1;
        lo_nxt     = lo_r + NW'(1);
      end
    end

    if (cmd.q_hi) begin
      if (pend_l_r) begin
        lacc_nxt = lacc_upd;
      end
      pend_l_nxt = 1'b0;
      if (hi_r[0]) begin
        re         = 1'b1;
        raddr      = hm1[AW-1:0];
        pend_r_nxt = 1'b1;
      end
      // for odd hi, (hi-1)>>1 equals hi>>1
      hi_nxt = hi_r >> 1;
      lo_nxt = lo_r >> 1;
    end

    if (cmd.q_fin) begin
      res_nxt = fin_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      pend_l_r <= 1'b0;
      pend_r_r <= 1'b0;
    end else begin
      clr_r    <= clr_nxt;
      pend_l_r <= pend_l_nxt;
      pend_r_r <= pend_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    cur_r  <= cur_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    lacc_r <= lacc_nxt;
    racc_r <= racc_nxt;
    res_r  <= res_nxt;
  end

  assign out_range_minimum = res_r;

  `ASSERT_IMPLY(a_climb_below_root, clk, rst_n, cmd.wr_up, node_r > AW'(1), "climb past root")
  `ASSERT_IMPLY(a_bounds_ordered, clk, rst_n, cmd.q_hi, lo_r <= hi_r, "query bounds crossed")
  `ASSERT_IMPLY(a_no_stale_left, clk, rst_n, cmd.q_lo, !pend_l_r, "left read not consumed")

endmodule

@@ design/rmst_ctrl.sv @@
// Controller of the range-minimum segment tree: clearing pass, write climb
// and query walk sequencing, result handshake. Uses rmst_pkg.
`include "range_min_segment_tree_unit_defines.svh"
module rmst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rmst_pkg::dp_sts_t sts,
  output rmst_pkg::dp_cmd_t cmd
);

  import rmst_pkg::*;

  typedef enum logic [7:0] {
    S_CLR    = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_W_LEAF = 8'b0000_0100,
    S_W_RD   = 8'b0000_1000,
    S_W_UP   = 8'b0001_0000,
    S_Q_LO   = 8'b0010_0000,
    S_Q_HI   = 8'b0100_0000,
    S_Q_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_busy;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (sts.is_query) begin
            state_nxt = S_Q_LO;
          end else if (!sts.wr_oob) begin
            state_nxt = S_W_LEAF;
          end
        end
      end
      S_W_LEAF: begin
        cmd.wr_leaf = 1'b1;
        state_nxt   = S_W_UP;
      end
      S_W_RD: begin
        cmd.rd_sib = 1'b1;
        state_nxt  = S_W_UP;
      end
      S_W_UP: begin
        cmd.wr_up = 1'b1;
        state_nxt = sts.at_root ? S_IDLE : S_W_RD;
      end
      S_Q_LO: begin
        cmd.q_lo  = 1'b1;
        state_nxt = sts.lo_lt_hi ? S_Q_HI : S_Q_FIN;
      end
      S_Q_HI: begin
        cmd.q_hi  = 1'b1;
        state_nxt = S_Q_LO;
      end
      S_Q_FIN: begin
        if (!slot_busy) begin
          cmd.q_fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.q_fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_clr_exits_idle, clk, rst_n, state_r == S_CLR, state_r == S_CLR || state_r == S_IDLE, "clear pass left early")
  `ASSERT_NEXT(a_write_no_query, clk, rst_n, accept && !sts.is_query, state_r == S_IDLE || state_r == S_W_LEAF, "write entered query walk")
  `ASSERT_NEXT(a_result_held, clk, rst_n, state_r == S_Q_FIN && slot_busy, state_r == S_Q_FIN && out_valid_r, "result dropped under stall")
  `ASSERT_IMPLY(a_fin_only_free, clk, rst_n, cmd.q_fin, !slot_busy, "result register overwritten")

endmodule
